/* rtl/core/kvi_pkg.sv */
package kvi_pkg;

	localparam int MAX_KEYS_DEF = 64;

	localparam int KEY_CNT_W = 7;
	localparam int IDX_W     = 6;
	localparam int TIME_W    = 32;
	localparam int VAL_W     = 32;
	localparam int FRAC_W    = 32;

	// restoring divider steps and blend lane latency share one counter
	localparam int CNT_W        = $clog2(FRAC_W);
	localparam int BLEND_CYCLES = 3;

	// stream packing, lowest bit first
	localparam int KEY_INDEX_LSB  = 0;
	localparam int KEY_TIME_LSB   = KEY_INDEX_LSB + IDX_W;
	localparam int KEY_X_LSB      = KEY_TIME_LSB + TIME_W;
	localparam int KEY_Y_LSB      = KEY_X_LSB + VAL_W;
	localparam int KEY_Z_LSB      = KEY_Y_LSB + VAL_W;
	localparam int QUERY_TIME_LSB = KEY_Z_LSB + VAL_W;
	localparam int IN_FIELDS_W    = QUERY_TIME_LSB + TIME_W;
	localparam int IN_DATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W     = 3 * VAL_W;
	localparam int OUT_USER_W     = 2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [VAL_W-1:0]  x;
		logic [VAL_W-1:0]  y;
		logic [VAL_W-1:0]  z;
	} kvi_key_t;

	typedef struct packed {
		logic             held_first;
		logic             held_last;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] z;
	} kvi_res_t;

	typedef enum logic [2:0] {
		ADDR_LAST,
		ADDR_ZERO,
		ADDR_MID,
		ADDR_I0,
		ADDR_I1
	} addr_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_HOLD_LAST,
		RES_HOLD_FIRST,
		RES_BLEND
	} res_op_t;

	typedef struct packed {
		logic      load;
		logic      key_wr;
		addr_sel_t addr_sel;
		logic      search_upd;
		logic      latch_a;
		logic      latch_b;
		logic      frac_setup;
		logic      div_init;
		logic      div_step;
		res_op_t   res_op;
		logic      out_load;
	} kvi_cmd_t;

	typedef struct packed {
		logic t_ge_key;
		logic search_done;
		logic frac_trivial;
	} kvi_sts_t;

endpackage

/* rtl/core/kvi_ram.sv */
module kvi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/kvi_lane.sv */
module kvi_lane import kvi_pkg::*; (
	input  logic              clk,
	input  logic [VAL_W-1:0]  a,
	input  logic [VAL_W-1:0]  b,
	input  logic [FRAC_W-1:0] frac,
	output logic [VAL_W-1:0]  r
);

	logic [VAL_W:0]    d_s1;
	logic [VAL_W-1:0]  a_s1, a_s2, a_s3, a_s4;
	logic [VAL_W-1:0]  mag_s2;
	logic              neg_s2, neg_s3, neg_s4;
	logic [47:0]       hi_s3, lo_s3;
	logic [48:0]       sum_d;
	logic [VAL_W:0]    q_s4;
	logic [VAL_W:0]    neg_d;

	assign neg_d = -d_s1;
	assign sum_d = {1'b0, hi_s3} + 49'(lo_s3[47:16]);

	always_ff @(posedge clk) begin
		d_s1   <= {b[VAL_W-1], b} - {a[VAL_W-1], a};
		a_s1   <= a;
		// |b - a| stays below 2^32
		neg_s2 <= d_s1[VAL_W];
		mag_s2 <= d_s1[VAL_W] ? neg_d[VAL_W-1:0] : d_s1[VAL_W-1:0];
		a_s2   <= a_s1;
		hi_s3  <= 48'(mag_s2) * 48'(frac[31:16]);
		lo_s3  <= 48'(mag_s2) * 48'(frac[15:0]);
		neg_s3 <= neg_s2;
		a_s3   <= a_s2;
		q_s4   <= sum_d[48:16];
		neg_s4 <= neg_s3;
		a_s4   <= a_s3;
	end

	// truncation toward a, result stays between the two keys
	assign r = neg_s4 ? a_s4 - q_s4[VAL_W-1:0] : a_s4 + q_s4[VAL_W-1:0];

endmodule

/* rtl/core/kvi_dp.sv */
module kvi_dp import kvi_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [KEY_CNT_W-1:0]  cfg_wdata,
	input  logic [IN_DATA_W-1:0]  in_tdata,
	input  kvi_cmd_t              cmd,
	output kvi_sts_t              sts,
	output logic [OUT_DATA_W-1:0] out_tdata,
	output logic [OUT_USER_W-1:0] out_tuser
);

	localparam int AW = $clog2(MAX_KEYS);
	localparam int NW = $clog2(MAX_KEYS + 1);

	logic [KEY_CNT_W-1:0] key_count_q;
	logic [IDX_W-1:0]     key_index;
	logic [TIME_W-1:0]    query_time;
	kvi_key_t             wr_key, rd_key;
	logic                 ram_we;
	logic [AW-1:0]        raddr;
	logic [$bits(kvi_key_t)-1:0] rd_data;

	logic [NW-1:0] n_d, last_n;
	logic [AW-1:0] last_d;
	logic [NW-1:0] left_q, right_q, left_nx, right_nx;
	logic [NW:0]   sum_cur, sum_nx;
	logic [NW-1:0] mid_cur, mid_nx, inc_d, i1_d;

	logic [TIME_W-1:0] t_q;
	kvi_key_t          key_a_q, key_b_q;
	logic [TIME_W-1:0] den_q, rem_q;
	logic              degen_q;
	logic [FRAC_W-1:0] frac_q;
	logic [TIME_W:0]   rem_x2, rem_sub;
	logic              rem_ge;
	logic [VAL_W-1:0]  bl_x, bl_y, bl_z;
	kvi_res_t          res_q, out_q;

	assign key_index  = in_tdata[KEY_INDEX_LSB +: IDX_W];
	assign query_time = in_tdata[QUERY_TIME_LSB +: TIME_W];
	assign wr_key.t   = in_tdata[KEY_TIME_LSB +: TIME_W];
	assign wr_key.x   = in_tdata[KEY_X_LSB +: VAL_W];
	assign wr_key.y   = in_tdata[KEY_Y_LSB +: VAL_W];
	assign wr_key.z   = in_tdata[KEY_Z_LSB +: VAL_W];

	// slots beyond the table are dropped
	assign ram_we = cmd.key_wr && (32'(key_index) < 32'(MAX_KEYS));

	always_comb begin
		if (key_count_q == '0) begin
			n_d = NW'(1);
		end else if (32'(key_count_q) > 32'(MAX_KEYS)) begin
			n_d = NW'(MAX_KEYS);
		end else begin
			n_d = NW'(key_count_q);
		end
	end

	assign last_n = n_d - NW'(1);
	assign last_d = AW'(last_n);

	// binary search: update bounds with the probe that just came back
	assign sum_cur = {1'b0, left_q} + {1'b0, right_q};
	assign mid_cur = sum_cur[NW:1];
	assign left_nx  = (cmd.search_upd && rd_key.t < t_q)  ? mid_cur : left_q;
	assign right_nx = (cmd.search_upd && rd_key.t >= t_q) ? mid_cur : right_q;
	assign sum_nx  = {1'b0, left_nx} + {1'b0, right_nx};
	assign mid_nx  = sum_nx[NW:1];
	assign inc_d   = left_nx + NW'(1);
	assign i1_d    = (inc_d > last_n) ? last_n : inc_d;

	always_comb begin
		case (cmd.addr_sel)
			ADDR_LAST: raddr = last_d;
			ADDR_ZERO: raddr = '0;
			ADDR_MID:  raddr = AW'(mid_nx);
			ADDR_I0:   raddr = AW'(left_nx);
			ADDR_I1:   raddr = AW'(i1_d);
			default:   raddr = '0;
		endcase
	end

	kvi_ram #(
		.WIDTH($bits(kvi_key_t)),
		.DEPTH(MAX_KEYS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(key_index)),
		.wdata(wr_key),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign rd_key = kvi_key_t'(rd_data);

	assign sts.t_ge_key     = t_q >= rd_key.t;
	assign sts.search_done  = (right_nx - left_nx) <= NW'(1);
	assign sts.frac_trivial = degen_q || (rem_q >= den_q);

	assign rem_x2  = {rem_q, 1'b0};
	assign rem_ge  = rem_x2 >= {1'b0, den_q};
	assign rem_sub = rem_x2 - {1'b0, den_q};

	kvi_lane u_lane_x (.clk(clk), .a(key_a_q.x), .b(key_b_q.x), .frac(frac_q), .r(bl_x));
	kvi_lane u_lane_y (.clk(clk), .a(key_a_q.y), .b(key_b_q.y), .frac(frac_q), .r(bl_y));
	kvi_lane u_lane_z (.clk(clk), .a(key_a_q.z), .b(key_b_q.z), .frac(frac_q), .r(bl_z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KEY_CNT_W'(1);
		end else if (cfg_wen) begin
			key_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q     <= query_time;
			left_q  <= '0;
			right_q <= n_d;
		end else if (cmd.search_upd) begin
			left_q  <= left_nx;
			right_q <= right_nx;
		end
		if (cmd.latch_a) begin
			key_a_q <= rd_key;
		end
		if (cmd.latch_b) begin
			key_b_q <= rd_key;
		end
		if (cmd.frac_setup) begin
			den_q   <= key_b_q.t - key_a_q.t;
			rem_q   <= (t_q > key_a_q.t) ? t_q - key_a_q.t : '0;
			degen_q <= key_b_q.t <= key_a_q.t;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[TIME_W-1:0] : rem_x2[TIME_W-1:0];
		end
		if (cmd.div_init) begin
			frac_q <= (!degen_q && rem_q >= den_q) ? '1 : '0;
		end else if (cmd.div_step) begin
			frac_q <= {frac_q[FRAC_W-2:0], rem_ge};
		end
		case (cmd.res_op)
			RES_HOLD_LAST:  res_q <= '{held_first: 1'b0, held_last: 1'b1,
				x: rd_key.x, y: rd_key.y, z: rd_key.z};
			RES_HOLD_FIRST: res_q <= '{held_first: 1'b1, held_last: 1'b0,
				x: rd_key.x, y: rd_key.y, z: rd_key.z};
			RES_BLEND:      res_q <= '{held_first: 1'b0, held_last: 1'b0,
				x: bl_x, y: bl_y, z: bl_z};
			default:        res_q <= res_q;
		endcase
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign out_tdata = {out_q.z, out_q.y, out_q.x};
	assign out_tuser = {out_q.held_first, out_q.held_last};

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search_upd |=> left_q < right_q)
		else $error("search bounds crossed");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	a_seg_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.addr_sel == ADDR_I1 |-> i1_d == left_q + NW'(1))
		else $error("segment end key is not next to segment start");

endmodule

/* rtl/core/kvi_ctrl.sv */
module kvi_ctrl import kvi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     s_tuser,
	output logic     s_tready,
	input  logic     m_tready,
	output logic     m_tvalid,
	input  kvi_sts_t sts,
	output kvi_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK_LAST,
		S_CHK_FIRST,
		S_SEARCH,
		S_GET_A,
		S_GET_B,
		S_SETUP,
		S_DIV_CHK,
		S_DIV,
		S_BLEND,
		S_DONE
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd          = '0;
		cmd.addr_sel = ADDR_LAST;
		cmd.res_op   = RES_NONE;
		state_d      = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser == CMD_QUERY) begin
						cmd.load = 1'b1;
						state_d  = S_CHK_LAST;
					end else begin
						cmd.key_wr = 1'b1;
					end
				end
			end
			S_CHK_LAST: begin
				if (sts.t_ge_key) begin
					cmd.res_op = RES_HOLD_LAST;
					state_d    = S_DONE;
				end else begin
					cmd.addr_sel = ADDR_ZERO;
					state_d      = S_CHK_FIRST;
				end
			end
			S_CHK_FIRST: begin
				if (!sts.t_ge_key) begin
					cmd.res_op = RES_HOLD_FIRST;
					state_d    = S_DONE;
				end else if (sts.search_done) begin
					cmd.addr_sel = ADDR_I0;
					state_d      = S_GET_A;
				end else begin
					cmd.addr_sel = ADDR_MID;
					state_d      = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search_upd = 1'b1;
				if (sts.search_done) begin
					cmd.addr_sel = ADDR_I0;
					state_d      = S_GET_A;
				end else begin
					cmd.addr_sel = ADDR_MID;
				end
			end
			S_GET_A: begin
				cmd.latch_a  = 1'b1;
				cmd.addr_sel = ADDR_I1;
				state_d      = S_GET_B;
			end
			S_GET_B: begin
				cmd.latch_b = 1'b1;
				state_d     = S_SETUP;
			end
			S_SETUP: begin
				cmd.frac_setup = 1'b1;
				state_d        = S_DIV_CHK;
			end
			S_DIV_CHK: begin
				cmd.div_init = 1'b1;
				state_d      = sts.frac_trivial ? S_BLEND : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(FRAC_W - 1)) begin
					state_d = S_BLEND;
				end
			end
			S_BLEND: begin
				// wait for the lanes to drain the new fraction
				if (cnt_q == CNT_W'(BLEND_CYCLES - 1)) begin
					cmd.res_op = RES_BLEND;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d == state_q) ? cnt_q + CNT_W'(1) : '0;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("result loaded over an untaken result");

	a_out_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

	a_blend_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BLEND && cnt_q == '0) |->
		$past(state_q == S_DIV || state_q == S_DIV_CHK))
		else $error("blend started without a fraction");

endmodule

/* rtl/core/keyframe_vector_interpolator_core.sv */
// channel  dir  tdata  tuser  transfer
// s_axis   in   168    1      key write (tuser 0) or time query (tuser 1)
// m_axis   out  96     2      interpolated vector and hold flags, one per query
// cfg      in   7      -      key_count write, taken on every cycle with cfg_wen
//
// key write: the table slot is written on the accepting edge and the block stays ready
// query held at an end key: checked against the last key, then the first, then loaded
// interpolating query: binary search, reads of the segment keys, divider and blend; the
// divide is skipped when the segment is empty or t is at its end
// reset: key_count = 1, key table contents undefined until written
// a finished result waits in the output register; the next item is taken meanwhile
module keyframe_vector_interpolator_core import kvi_pkg::*; #(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [KEY_CNT_W-1:0]  cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// key_index, key_time, key_x, key_y, key_z, query_time, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_x, out_y, out_z
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// held_last, held_first
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	kvi_cmd_t cmd;
	kvi_sts_t sts;

	kvi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tuser (s_axis_tuser),
		.s_tready(s_axis_tready),
		.m_tready(m_axis_tready),
		.m_tvalid(m_axis_tvalid),
		.sts     (sts),
		.cmd     (cmd)
	);

	kvi_dp #(
		.MAX_KEYS(MAX_KEYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_tdata (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_tdata(m_axis_tdata),
		.out_tuser(m_axis_tuser)
	);

endmodule

/* sim/tb_keyframe_vector_interpolator_core.sv */
`timescale 1ns / 1ps

module tb_keyframe_vector_interpolator_core import kvi_pkg::*; ();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_HOLD    = 400;

	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  slot;
		kvi_key_t          key;
		logic [TIME_W-1:0] query_t;
	} stim_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [KEY_CNT_W-1:0]  cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	// predictor state: key table updated on accepted transfers, key count on cfg writes
	kvi_key_t             key_table [MAX_KEYS_DEF];
	logic [KEY_CNT_W-1:0] key_count_q = KEY_CNT_W'(1);

	// stimulus side copy of the key times, used to aim queries and to rewrite keys at their times
	logic [TIME_W-1:0] plan_time [MAX_KEYS_DEF];

	stim_item_t input_backlog [$];
	kvi_res_t   awaited_vectors [$];
	stim_item_t cur_item;

	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_reqs = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	keyframe_vector_interpolator_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned effective_keys(input logic [KEY_CNT_W-1:0] k);
		if (k == 0)
			return 1;
		if (k > MAX_KEYS_DEF)
			return MAX_KEYS_DEF;
		return 32'(k);
	endfunction

	// a + (b - a) * frac / 2^32, truncated toward a
	function automatic logic [VAL_W-1:0] lerp(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b, input logic [FRAC_W-1:0] frac);
		logic signed [VAL_W+1:0] a_w, b_w, diff, step, sum;
		logic [VAL_W+1:0]        mag;
		logic [2*VAL_W+1:0]      prod;
		a_w = (VAL_W+2)'($signed(a));
		b_w = (VAL_W+2)'($signed(b));
		diff = b_w - a_w;
		mag = diff[VAL_W+1] ? $unsigned(-diff) : $unsigned(diff);
		prod = {{VAL_W{1'b0}}, mag} * {{(VAL_W+2){1'b0}}, frac};
		step = $signed(prod[2*VAL_W+1:FRAC_W]);
		sum = diff[VAL_W+1] ? a_w - step : a_w + step;
		return sum[VAL_W-1:0];
	endfunction

	function automatic kvi_res_t interpolate_at(input logic [TIME_W-1:0] qt);
		int unsigned       n, last, lo, hi, mid, i0, i1;
		logic [TIME_W-1:0] t0, t1, span, ofs;
		logic [63:0]       scaled;
		logic [FRAC_W-1:0] frac;
		kvi_res_t          r;
		r = '0;
		n = effective_keys(key_count_q);
		last = n - 1;
		if (qt >= key_table[last].t) begin
			r.x = key_table[last].x;
			r.y = key_table[last].y;
			r.z = key_table[last].z;
			r.held_last = 1'b1;
			return r;
		end
		if (qt < key_table[0].t) begin
			r.x = key_table[0].x;
			r.y = key_table[0].y;
			r.z = key_table[0].z;
			r.held_first = 1'b1;
			return r;
		end
		lo = 0;
		hi = n;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (key_table[mid].t < qt)
				lo = mid;
			else
				hi = mid;
		end
		i0 = lo;
		i1 = (lo + 1 > last) ? last : lo + 1;
		t0 = key_table[i0].t;
		t1 = key_table[i1].t;
		if (t1 <= t0) begin
			frac = '0;
		end else begin
			span = t1 - t0;
			ofs = (qt > t0) ? qt - t0 : '0;
			if (ofs >= span) begin
				frac = '1;
			end else begin
				scaled = {ofs, 32'd0} / {32'd0, span};
				frac = scaled[FRAC_W-1:0];
			end
		end
		r.x = lerp(key_table[i0].x, key_table[i1].x, frac);
		r.y = lerp(key_table[i0].y, key_table[i1].y, frac);
		r.z = lerp(key_table[i0].z, key_table[i1].z, frac);
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] rand_component();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic put_key(input int unsigned slot, input logic [TIME_W-1:0] t,
			input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] z);
		stim_item_t it;
		it.cmd = CMD_WRITE;
		it.slot = IDX_W'(slot);
		it.key.t = t;
		it.key.x = x;
		it.key.y = y;
		it.key.z = z;
		it.query_t = $urandom;
		plan_time[slot] = t;
		input_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic put_query(input logic [TIME_W-1:0] t);
		stim_item_t it;
		it.cmd = CMD_QUERY;
		it.slot = IDX_W'($urandom_range(0, MAX_KEYS_DEF - 1));
		it.key.t = $urandom;
		it.key.x = $urandom;
		it.key.y = $urandom;
		it.key.z = $urandom;
		it.query_t = t;
		input_backlog.push_back(it);
		items_queued++;
	endtask

	// block goes quiet: all transfers taken, all results back, then some slack
	task automatic settle();
		while (items_taken != items_queued || awaited_vectors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_key_count(input logic [KEY_CNT_W-1:0] k);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_wen <= 1'b0;
		key_count_q = k;
	endtask

	task automatic run_phase(input logic [KEY_CNT_W-1:0] k, input int unsigned mode,
			input int unsigned queries, input bit long_hold);
		int unsigned       n, shape, i, j;
		logic [TIME_W-1:0] t, maxgap;
		settle();
		set_key_count(k);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
			default: begin send_idle_pct = 10; recv_stall_pct = 10; end
		endcase
		n = effective_keys(k);
		shape = $urandom_range(0, 9);
		maxgap = 32'hFFFF_FFF0 / n;
		t = (shape == 5 || shape == 6) ? $urandom_range(0, 32'h7FFF_FFFF)
			: $urandom_range(0, 15);
		for (i = 0; i < n; i++) begin
			if (shape == 8)
				t = $urandom_range(0, 255);
			else if (n == 1)
				t = $urandom;
			else if (i > 0)
				t = t + ((shape == 5 || shape == 6) ? $urandom_range(1, 4)
					: $urandom_range(1, maxgap));
			// full span table: first key at zero, last at the top of the range
			if (shape == 7 && n >= 2 && i == 0)
				t = '0;
			if (shape == 7 && n >= 2 && i == n - 1)
				t = '1;
			put_key(i, t, rand_component(), rand_component(), rand_component());
		end
		if (long_hold)
			hold_reqs++;
		for (i = 0; i < queries; i++) begin
			if ($urandom_range(0, 24) == 0) begin
				j = $urandom_range(0, n - 1);
				put_key(j, plan_time[j], rand_component(), rand_component(), rand_component());
			end
			case ($urandom_range(0, 19))
				0: t = (plan_time[0] == 0) ? '0 : $urandom_range(0, plan_time[0] - 1);
				1: t = $urandom_range(plan_time[n-1], 32'hFFFF_FFFF);
				2: t = plan_time[$urandom_range(0, n - 1)];
				3: t = $urandom;
				4: t = $urandom_range(0, 1) ? '0 : '1;
				default: begin
					if (n >= 2) begin
						j = $urandom_range(0, n - 2);
						t = $urandom_range(plan_time[j], plan_time[j+1]);
					end else begin
						t = $urandom;
					end
				end
			endcase
			put_query(t);
		end
	endtask

	// driver: one item on the slave channel, prediction made at its transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (cur_item.cmd == CMD_QUERY)
					awaited_vectors.push_back(interpolate_at(cur_item.query_t));
				else
					key_table[cur_item.slot] = cur_item.key;
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (input_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_item = input_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= cur_item.cmd;
					s_axis_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, cur_item.query_t,
						cur_item.key.z, cur_item.key.y, cur_item.key.x, cur_item.key.t,
						cur_item.slot};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// monitor: checks each result transfer and drives the receiver's stalls
	always @(posedge clk) begin
		kvi_res_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_vectors.size() == 0) begin
					$display("%0t ns: result with none expected, actual %h / %b", $time,
						m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					want = awaited_vectors.pop_front();
					check_field("out_x", want.x, m_axis_tdata[VAL_W-1:0]);
					check_field("out_y", want.y, m_axis_tdata[2*VAL_W-1:VAL_W]);
					check_field("out_z", want.z, m_axis_tdata[3*VAL_W-1:2*VAL_W]);
					check_field("held_last", VAL_W'(want.held_last), VAL_W'(m_axis_tuser[0]));
					check_field("held_first", VAL_W'(want.held_first),
						VAL_W'(m_axis_tuser[1]));
				end
			end
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// single key at reset count: before, on and after its time
		put_key(0, 1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		put_query(0);
		put_query(999);
		put_query(1000);
		put_query(32'hFFFF_FFFF);

		// a zero count behaves as one key
		settle();
		set_key_count(0);
		put_query(500);
		put_query(1000);

		// extreme vectors and times, query on an interior key
		settle();
		set_key_count(3);
		put_key(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		put_key(1, 10, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		put_key(2, 32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678, 32'h8000_0000);
		put_query(0);
		put_query(5);
		put_query(9);
		put_query(10);
		put_query(32'h7FFF_FFFF);
		put_query(32'hFFFF_FFFE);
		put_query(32'hFFFF_FFFF);

		// repeated key time: zero length segment gives its start key
		put_key(1, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
		put_key(2, 20, 32'h0005_0000, 32'h0003_0000, 32'hFFFF_8000);
		put_query(0);
		put_query(5);
		put_query(19);

		run_phase(2, 0, 40, 1'b1);
		run_phase(64, 1, 40, 1'b0);
		run_phase(127, 2, 40, 1'b0);
		run_phase(0, 3, 25, 1'b0);
		run_phase(1, 0, 25, 1'b0);
		run_phase(5, 1, 40, 1'b0);
		run_phase(64, 2, 45, 1'b0);
		run_phase(17, 3, 40, 1'b0);
		run_phase(3, 0, 40, 1'b0);
		run_phase(33, 1, 40, 1'b0);
		run_phase(8, 2, 40, 1'b0);
		run_phase(2, 3, 40, 1'b0);
		settle();

		if (mismatches == 0 && awaited_vectors.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
